// ----- hw/rtl/dnt_pkg.sv -----
// shared types and codes for the directory name table
package dnt_pkg;

  // operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_LOAD   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // control states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_t;

  // one input item
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] name_key;
    logic [23:0] extension_key;
    logic [3:0]  load_index;
    logic [15:0] load_date;
    logic [15:0] load_time;
    logic [31:0] load_size;
    logic [31:0] load_start;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_index;
    logic [31:0] found_start;
    logic [31:0] found_size;
    logic [15:0] found_date;
    logic [15:0] found_time;
    logic        exists_flag;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic [63:0] name;
    logic [23:0] ext;
    logic [15:0] date;
    logic [15:0] tim;
    logic [31:0] size;
    logic [31:0] start;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

endpackage

// ----- hw/rtl/dnt_if.sv -----
// valid/ready channel interfaces for input and result items
interface dnt_in_if;
  logic                valid;
  logic                ready;
  dnt_pkg::in_item_t   item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface dnt_out_if;
  logic                valid;
  logic                ready;
  dnt_pkg::out_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ----- hw/rtl/directory_name_table.sv -----
// directory name table: lookup, create, delete and load over a ram-held table
// sequence: a load goes from accept straight to the result state; lookup, create and delete
//   first scan the table in index order, comparing each registered read word, and stop at
//   the first hit or after the last entry before the result is assembled
// flow: one item at a time, next accept in the cycle after the result is loaded; a result
//   is loaded only once the previous one has gone, so result stalls hold the block
// reset: synchronous active-low; per-entry valid bits clear so the table reads as zero
module directory_name_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dnt_in_if.sink    in_ch,
  dnt_out_if.source out_ch
);
  import dnt_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CntEnd  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CntLast = CW'(TABLE_ENTRIES - 1);

  state_t            state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              chk_vld_r;
  logic [IW-1:0]     chk_idx_r;
  logic              chk_last_r;
  logic              rd_vld_r;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hit_idx_r, hit_idx_nxt;
  entry_t            hit_data_r, hit_data_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  out_item_t         out_item_r, out_item_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              we;
  logic [IW-1:0]     waddr;
  entry_t            wdata;
  logic [EntryBits-1:0] ram_q;
  entry_t            eff;
  logic              key_match, is_free, chk_hit;
  logic              out_load;
  logic              ld_in_range;
  logic [IW-1:0]     ld_addr;
  entry_t            rep;

  // table storage
  dnt_ram #(
    .WIDTH (EntryBits),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // entry as seen after reset: never-written entries read as zero
  always_comb begin
    eff       = rd_vld_r ? entry_t'(ram_q) : '0;
    key_match = (eff.name == req_r.name_key) && (eff.ext == req_r.extension_key);
    is_free   = (eff.name[7:0] == 8'd0);
    chk_hit   = (op_t'(req_r.operation) == OP_CREATE) ? is_free : key_match;
  end

  assign rd_en       = (state_r == S_SCAN) && (cnt_r < CntEnd);
  assign rd_addr     = cnt_r[IW-1:0];
  assign ld_in_range = (32'(req_r.load_index) < 32'(TABLE_ENTRIES));
  assign ld_addr     = IW'(req_r.load_index);
  assign out_load    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  // next state, scan control and result assembly
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_data_nxt  = hit_data_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    waddr         = hit_idx_r;
    wdata         = hit_data_r;
    rep           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.item;
          cnt_nxt = '0;
          hit_nxt = 1'b0;
          state_nxt = (op_t'(in_ch.item.operation) == OP_LOAD) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        // compare the word read last cycle
        if (chk_vld_r) begin
          if (chk_hit) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = chk_idx_r;
            hit_data_nxt = eff;
            state_nxt    = S_FIN;
          end else if (chk_last_r) begin
            hit_nxt   = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          unique case (op_t'(req_r.operation))
            OP_LOAD: begin
              rep.name  = req_r.name_key;
              rep.ext   = req_r.extension_key;
              rep.date  = req_r.load_date;
              rep.tim   = req_r.load_time;
              rep.size  = req_r.load_size;
              rep.start = req_r.load_start;
              we        = ld_in_range;
              waddr     = ld_addr;
              wdata     = rep;
            end
            OP_CREATE: begin
              rep      = hit_data_r;
              rep.name = req_r.name_key;
              rep.ext  = req_r.extension_key;
              we       = hit_r;
              wdata    = rep;
            end
            OP_DELETE: begin
              rep      = hit_data_r;
              rep.name = '0;
              rep.ext  = '0;
              we       = hit_r;
              wdata    = rep;
            end
            OP_LOOKUP: begin
              rep = hit_data_r;
            end
            default: begin
              rep = hit_data_r;
            end
          endcase
          // report the entry or a cleared miss
          if ((op_t'(req_r.operation) == OP_LOAD) ? ld_in_range : hit_r) begin
            out_item_nxt.status      = ST_DONE;
            out_item_nxt.found_index =
              4'((op_t'(req_r.operation) == OP_LOAD) ? ld_addr : hit_idx_r);
            out_item_nxt.found_start = rep.start;
            out_item_nxt.found_size  = rep.size;
            out_item_nxt.found_date  = rep.date;
            out_item_nxt.found_time  = rep.tim;
            out_item_nxt.exists_flag = (rep.start != 32'd0);
          end else if (op_t'(req_r.operation) == OP_CREATE) begin
            out_item_nxt.status = ST_FULL;
          end else begin
            out_item_nxt.status = ST_NOT_FOUND;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      hit_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      cnt_r       <= cnt_nxt;
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_data_r <= hit_data_nxt;
    out_item_r <= out_item_nxt;
    if (rd_en) begin
      chk_idx_r  <= rd_addr;
      chk_last_r <= (cnt_r == CntLast);
      rd_vld_r   <= valid_r[rd_addr];
    end
  end

  // table writes only happen while a result is being produced
  a_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> out_load)
    else $error("table write outside result cycle");

  // a compare always follows a ram read issued the cycle before
  a_chk_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> $past(rd_en))
    else $error("compare without a preceding read");

  // table full is only ever reported for a create
  a_full_is_create: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_item_nxt.status == ST_FULL) |->
      (op_t'(req_r.operation) == OP_CREATE))
    else $error("table full reported for a non-create item");

  // a new result is only loaded once the previous one has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");

  // the scan never reads past the last entry
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (cnt_r <= CntLast))
    else $error("scan read past table end");

endmodule

// ----- hw/rtl/dnt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module dnt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- bench/dnt_result_checker.sv -----
// result checker for the directory name table: mirrors the table and compares every result item
module dnt_result_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dnt_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dnt_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 outstanding
);
  import dnt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored directory contents
  entry_t    dir_tab [TABLE_ENTRIES];
  // results still owed by the block, oldest first
  out_item_t expected_results [$];
  int        n_fail = 0;

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  // metadata of one entry as the block reports it
  function automatic out_item_t entry_report(int idx);
    out_item_t r;
    r = '0;
    r.status      = ST_DONE;
    r.found_index = 4'(idx);
    r.found_start = dir_tab[idx].start;
    r.found_size  = dir_tab[idx].size;
    r.found_date  = dir_tab[idx].date;
    r.found_time  = dir_tab[idx].tim;
    r.exists_flag = (dir_tab[idx].start != 32'd0);
    return r;
  endfunction

  // run one directory operation on the mirror and return its result
  function automatic out_item_t apply_dir_op(in_item_t rq);
    out_item_t r;
    int        hit;
    r = '0;
    r.status = ST_NOT_FOUND;
    hit = -1;
    case (op_t'(rq.operation))
      OP_LOOKUP, OP_DELETE: begin
        // lowest entry with matching name and extension
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (hit < 0 && dir_tab[i].name == rq.name_key && dir_tab[i].ext == rq.extension_key)
            hit = i;
        end
        if (hit >= 0) begin
          if (op_t'(rq.operation) == OP_DELETE) begin
            dir_tab[hit].name = '0;
            dir_tab[hit].ext  = '0;
          end
          r = entry_report(hit);
        end
      end
      OP_CREATE: begin
        // lowest entry whose first name byte is zero
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (hit < 0 && dir_tab[i].name[7:0] == 8'd0)
            hit = i;
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          dir_tab[hit].name = rq.name_key;
          dir_tab[hit].ext  = rq.extension_key;
          r = entry_report(hit);
        end
      end
      default: begin
        if (rq.load_index < TABLE_ENTRIES) begin
          hit = int'(rq.load_index);
          dir_tab[hit].name  = rq.name_key;
          dir_tab[hit].ext   = rq.extension_key;
          dir_tab[hit].date  = rq.load_date;
          dir_tab[hit].tim   = rq.load_time;
          dir_tab[hit].size  = rq.load_size;
          dir_tab[hit].start = rq.load_start;
          r = entry_report(hit);
        end
      end
    endcase
    return r;
  endfunction

  // count a failure, print the first few
  function automatic void note_failure(string what, out_item_t exp, out_item_t got);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%0t: %0s", $realtime, what);
      $display("  expected st=%0d idx=%0d start=%h size=%h date=%h tim=%h ex=%b",
               exp.status, exp.found_index, exp.found_start, exp.found_size,
               exp.found_date, exp.found_time, exp.exists_flag);
      $display("  actual   st=%0d idx=%0d start=%h size=%h date=%h tim=%h ex=%b",
               got.status, got.found_index, got.found_start, got.found_size,
               got.found_date, got.found_time, got.exists_flag);
    end
  endfunction

  // watch both channels at every rising edge
  always @(posedge clk) begin
    out_item_t exp;
    if (!rst_n) begin
      foreach (dir_tab[i]) dir_tab[i] = '0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(apply_dir_op(in_item));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure("result item with nothing pending", '0, out_item);
        end else begin
          exp = expected_results.pop_front();
          if (out_item.status !== exp.status || out_item.found_index !== exp.found_index ||
              out_item.found_start !== exp.found_start ||
              out_item.found_size !== exp.found_size ||
              out_item.found_date !== exp.found_date ||
              out_item.found_time !== exp.found_time ||
              out_item.exists_flag !== exp.exists_flag)
            note_failure("result item mismatch", exp, out_item);
        end
      end
    end
    fail_count  <= n_fail;
    outstanding <= expected_results.size();
  end

endmodule

// ----- bench/directory_name_table_test.sv -----
// testbench top for the directory name table: reset, stimulus, handshake idling and verdict
module directory_name_table_test;
  import dnt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries     = 16;
  localparam int unsigned RandomItems = 1150;
  localparam logic [63:0] NameA       = 64'h2020_2045_4c49_4652;
  localparam logic [23:0] ExtA        = 24'h54_58_54;

  typedef struct packed {
    logic [63:0] name;
    logic [23:0] ext;
  } dir_key_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;
  int   fail_count;
  int   outstanding;

  dir_key_t known_keys [$];

  dnt_in_if  in_ch ();
  dnt_out_if out_ch ();

  directory_name_table #(
    .TABLE_ENTRIES(Entries)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dnt_result_checker #(
    .TABLE_ENTRIES(Entries)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_ch.item),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_item    (out_ch.item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // overall time limit
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // one request item with random load fields
  function automatic in_item_t build_item(op_t op, logic [63:0] nm, logic [23:0] ex);
    in_item_t rq;
    rq.operation     = op;
    rq.name_key      = nm;
    rq.extension_key = ex;
    rq.load_index    = 4'($urandom_range(Entries - 1));
    rq.load_date     = 16'($urandom);
    rq.load_time     = 16'($urandom);
    rq.load_size     = $urandom;
    rq.load_start    = ($urandom_range(99) < 15) ? 32'd0 : $urandom;
    return rq;
  endfunction

  // key from the recent pool, a variant of one, zero, or fresh
  function automatic dir_key_t random_key();
    dir_key_t    k;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      k = '0;
    end else if (r < 58 && known_keys.size() > 0) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
    end else if (r < 68 && known_keys.size() > 0) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      k.ext = 24'($urandom);
    end else begin
      k.name = {$urandom, $urandom};
      k.ext  = 24'($urandom);
      // name that leaves the entry looking free
      if ($urandom_range(9) == 0) k.name[7:0] = 8'd0;
    end
    return k;
  endfunction

  // present one item, idling first at random, and wait for its acceptance
  task automatic push_request(in_item_t rq);
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 38) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // directed corner cases
  task automatic run_directed();
    in_item_t rq;
    // all-zero key matches a free cleared entry
    push_request(build_item(OP_LOOKUP, 64'd0, 24'd0));
    // not found
    push_request(build_item(OP_DELETE, NameA, ExtA));
    // duplicate create, lowest match wins
    push_request(build_item(OP_CREATE, NameA, ExtA));
    push_request(build_item(OP_CREATE, NameA, ExtA));
    push_request(build_item(OP_LOOKUP, NameA, ExtA));
    push_request(build_item(OP_DELETE, NameA, ExtA));
    push_request(build_item(OP_LOOKUP, NameA, ExtA));
    // load extremes
    rq = build_item(OP_LOAD, '1, '1);
    rq.load_index = 4'(Entries - 1);
    rq.load_date  = '1;
    rq.load_time  = '1;
    rq.load_size  = '1;
    rq.load_start = '1;
    push_request(rq);
    push_request(build_item(OP_LOOKUP, '1, '1));
    rq = build_item(OP_LOAD, '0, '0);
    rq.load_index = '0;
    rq.load_date  = '0;
    rq.load_time  = '0;
    rq.load_size  = '0;
    rq.load_start = '0;
    push_request(rq);
    // create whose first name byte is zero keeps the entry free
    push_request(build_item(OP_CREATE, 64'hffff_ffff_ffff_ff00, '1));
    // fill the table, then one more create reports full
    repeat (Entries - 1)
      push_request(build_item(OP_CREATE, {$urandom, $urandom} | 64'd1, 24'($urandom)));
  endtask

  // random well-formed traffic over a shared key pool
  task automatic random_request();
    in_item_t    rq;
    dir_key_t    k;
    int unsigned pick;
    pick = $urandom_range(99);
    k = random_key();
    if (pick < 30)
      rq = build_item(OP_CREATE, k.name, k.ext);
    else if (pick < 58)
      rq = build_item(OP_LOOKUP, k.name, k.ext);
    else if (pick < 82)
      rq = build_item(OP_DELETE, k.name, k.ext);
    else
      rq = build_item(OP_LOAD, k.name, k.ext);
    if (op_t'(rq.operation) == OP_CREATE || op_t'(rq.operation) == OP_LOAD) begin
      known_keys.push_back(k);
      if (known_keys.size() > 40) void'(known_keys.pop_front());
    end
    push_request(rq);
  endtask

  // stimulus and verdict
  initial begin
    int wait_n;
    in_ch.valid <= 1'b0;
    in_ch.item  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int n = 0; n < RandomItems; n++) begin
      // long stretch with no idling on either side
      calm = (n >= 500 && n < 700);
      random_request();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_n = 0;
    while (outstanding != 0 && wait_n < 20000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dnt_pkg.sv
hw/rtl/dnt_if.sv
hw/rtl/dnt_ram.sv
hw/rtl/directory_name_table.sv
bench/dnt_result_checker.sv
bench/directory_name_table_test.sv
